@@ rtl/core/rgb2nv12_pkg.sv @@
`timescale 1ns / 1ps

package rgb2nv12_pkg;

    // Geometry limits and counter widths
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DIM_W       = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [DIM_W-1:0] MAX_WIDTH_C    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_C   = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
    localparam logic [DIM_W-1:0] MIN_DIM        = DIM_W'(2);

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Pixel and line store layout
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = CH_W + 1;
    localparam int STORE_W = 3 * SUM_W;

    // Fixed point coefficients, rounded to nearest
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS;
    localparam int ACC_W          = COEF_FRAC_BITS + 11;
    localparam longint unsigned FIX_ONE = 64'd1 << COEF_FRAC_BITS;

    localparam logic [COEF_W-1:0] C_Y_R = COEF_W'((257 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_Y_G = COEF_W'((504 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_Y_B = COEF_W'((98 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_U_R = COEF_W'((148 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_U_G = COEF_W'((291 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_UV  = COEF_W'((439 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_V_G = COEF_W'((368 * FIX_ONE + 500) / 1000);
    localparam logic [COEF_W-1:0] C_V_B = COEF_W'((71 * FIX_ONE + 500) / 1000);

    localparam logic [ACC_W-1:0] OFS_Y = ACC_W'(16 * FIX_ONE);
    localparam logic [ACC_W-1:0] OFS_C = ACC_W'(128 * FIX_ONE);

    // Raster position of the item being accepted
    typedef struct packed {
        logic             chroma_col;
        logic             odd_row;
        logic             frame_end;
        logic [IDX_W-1:0] idx;
    } pix_pos_t;

    // Line store write request
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [STORE_W-1:0] data;
    } store_wr_t;

    // Even dimension, clamped to 2..max
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] d;
        d = {v[DIM_W-1:1], 1'b0};
        if (d > maxv)
            d = {maxv[DIM_W-1:1], 1'b0};
        if (d < MIN_DIM)
            d = MIN_DIM;
        return d;
    endfunction

    // Drop fraction, clamp to 0..255
    function automatic logic [CH_W-1:0] fix_sat(input logic [ACC_W-1:0] t);
        logic [CH_W-1:0] res;
        if (t[ACC_W-1])
            res = '0;
        else if (|t[ACC_W-2:COEF_FRAC_BITS+CH_W])
            res = '1;
        else
            res = t[COEF_FRAC_BITS+CH_W-1:COEF_FRAC_BITS];
        return res;
    endfunction

endpackage

@@ rtl/core/rgb2nv12_ram.sv @@
`timescale 1ns / 1ps

module rgb2nv12_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rgb2nv12_raster.sv @@
`timescale 1ns / 1ps

module rgb2nv12_raster (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rgb2nv12_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgb2nv12_pkg::DIM_W-1:0]      cfg_data,
    input  logic                                accept,
    input  logic [rgb2nv12_pkg::PIX_W-1:0]      pixel,
    output rgb2nv12_pkg::pix_pos_t              pos,
    output logic [rgb2nv12_pkg::PIX_W-1:0]      left_pixel
);

    import rgb2nv12_pkg::*;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] left_reg;
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
    logic             col_end;
    logic             row_end;

    // Last column and row of the current geometry
    assign w_last  = eff_dim(frame_width_reg, MAX_WIDTH_C) - DIM_W'(1);
    assign h_last  = eff_dim(frame_height_reg, MAX_HEIGHT_C) - DIM_W'(1);
    assign col_end = DIM_W'(col_reg) >= w_last;
    assign row_end = DIM_W'(row_reg) >= h_last;

    assign pos.chroma_col = col_reg[0];
    assign pos.odd_row    = row_reg[0];
    assign pos.frame_end  = row_end && col_end;
    assign pos.idx        = col_reg[IDX_W:1];
    assign left_pixel     = left_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster counters and the even-column pixel of the pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (accept)
        begin
            if (!col_reg[0])
                left_reg <= pixel;
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/rgb2nv12_pipe.sv @@
`timescale 1ns / 1ps

module rgb2nv12_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rgb2nv12_pkg::PIX_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rgb2nv12_pkg::PIX_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic                                accept,
    input  rgb2nv12_pkg::pix_pos_t              pos,
    input  logic [rgb2nv12_pkg::PIX_W-1:0]      left_pixel,
    output logic                                rd_en,
    output logic [rgb2nv12_pkg::IDX_W-1:0]      rd_addr,
    input  logic [rgb2nv12_pkg::STORE_W-1:0]    rd_data,
    output rgb2nv12_pkg::store_wr_t             store_wr
);

    import rgb2nv12_pkg::*;

    logic go1, go2, go3;

    logic             v1_reg, v2_reg, v3_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] s1_left_reg;
    pix_pos_t         s1_pos_reg;

    logic [CH_W-1:0]  s2_luma_reg;
    logic             s2_cvalid_reg;
    logic             s2_fend_reg;
    logic [CH_W-1:0]  s2_ar_reg, s2_ag_reg, s2_ab_reg;

    logic [CH_W-1:0]  s3_luma_reg, s3_u_reg, s3_v_reg;
    logic             s3_cvalid_reg, s3_fend_reg;

    logic [CH_W-1:0]  r, g, b;
    logic [SUM_W-1:0] sr, sg, sb;
    logic [SUM_W:0]   qr, qg, qb;
    logic [ACC_W-1:0] luma_acc;
    logic [ACC_W-1:0] u_acc, v_acc;
    logic [ACC_W-1:0] ar_x, ag_x, ab_x;

    // Stall chain: a stage loads when it is empty or its item moves on
    assign go3 = !v3_reg || m_axis_tready;
    assign go2 = !v2_reg || go3;
    assign go1 = !v1_reg || go2;

    assign s_axis_tready = go1;
    assign accept        = s_axis_tvalid && go1;

    // Line store read for the pair above, issued with the accept
    assign rd_en   = accept;
    assign rd_addr = pos.idx;

    // Stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (go1)
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= s_axis_tdata;
            s1_left_reg <= left_pixel;
            s1_pos_reg  <= pos;
        end
    end

    // Horizontal pair sums, vertical averages and luma
    assign r  = s1_pix_reg[CH_W-1:0];
    assign g  = s1_pix_reg[2*CH_W-1:CH_W];
    assign b  = s1_pix_reg[3*CH_W-1:2*CH_W];
    assign sr = SUM_W'(r) + SUM_W'(s1_left_reg[CH_W-1:0]);
    assign sg = SUM_W'(g) + SUM_W'(s1_left_reg[2*CH_W-1:CH_W]);
    assign sb = SUM_W'(b) + SUM_W'(s1_left_reg[3*CH_W-1:2*CH_W]);

    assign qr = (SUM_W+1)'(sr) + (SUM_W+1)'(rd_data[3*SUM_W-1:2*SUM_W]);
    assign qg = (SUM_W+1)'(sg) + (SUM_W+1)'(rd_data[2*SUM_W-1:SUM_W]);
    assign qb = (SUM_W+1)'(sb) + (SUM_W+1)'(rd_data[SUM_W-1:0]);

    assign luma_acc = ACC_W'(C_Y_R) * ACC_W'(r) + ACC_W'(C_Y_G) * ACC_W'(g)
                    + ACC_W'(C_Y_B) * ACC_W'(b) + OFS_Y;

    // Even rows leave their pair sums for the row below
    assign store_wr.we   = v1_reg && go2 && s1_pos_reg.chroma_col && !s1_pos_reg.odd_row;
    assign store_wr.addr = s1_pos_reg.idx;
    assign store_wr.data = {sr, sg, sb};

    // Stage 2 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (go2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (go2 && v1_reg)
        begin
            s2_luma_reg   <= fix_sat(luma_acc);
            s2_cvalid_reg <= s1_pos_reg.chroma_col && s1_pos_reg.odd_row;
            s2_fend_reg   <= s1_pos_reg.frame_end;
            s2_ar_reg     <= qr[SUM_W:2];
            s2_ag_reg     <= qg[SUM_W:2];
            s2_ab_reg     <= qb[SUM_W:2];
        end
    end

    // Chroma from the 2x2 averages
    assign ar_x  = ACC_W'(s2_ar_reg);
    assign ag_x  = ACC_W'(s2_ag_reg);
    assign ab_x  = ACC_W'(s2_ab_reg);
    assign u_acc = OFS_C + ACC_W'(C_UV) * ab_x - ACC_W'(C_U_R) * ar_x
                 - ACC_W'(C_U_G) * ag_x;
    assign v_acc = OFS_C + ACC_W'(C_UV) * ar_x - ACC_W'(C_V_G) * ag_x
                 - ACC_W'(C_V_B) * ab_x;

    // Stage 3: result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (go3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (go3 && v2_reg)
        begin
            s3_luma_reg   <= s2_luma_reg;
            s3_cvalid_reg <= s2_cvalid_reg;
            s3_fend_reg   <= s2_fend_reg;
            s3_u_reg      <= s2_cvalid_reg ? fix_sat(u_acc) : '0;
            s3_v_reg      <= s2_cvalid_reg ? fix_sat(v_acc) : '0;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {s3_v_reg, s3_u_reg, s3_luma_reg};
    assign m_axis_tuser  = s3_cvalid_reg;
    assign m_axis_tlast  = s3_fend_reg;

endmodule

@@ rtl/core/rgb_to_nv12_converter_core.sv @@
`timescale 1ns / 1ps
// A result passes the input, stage 2 and result registers on its way to the output.
// Throughput: one pixel per clock while the output is not stalled; three register
// stages and a line store with one write and one registered read port per cycle.
// Reset (asynchronous, active low) clears the counters, the pair pixel and all
// valid flags, and sets the geometry to 640x480. The line store is not cleared.

module rgb_to_nv12_converter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rgb2nv12_pkg::PIX_W-1:0]      s_axis_tdata,   // red, green, blue
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rgb2nv12_pkg::PIX_W-1:0]      m_axis_tdata,   // luma, chroma_u, chroma_v
    output logic                                m_axis_tuser,   // chroma_valid
    output logic                                m_axis_tlast,   // frame_end
    input  logic                                cfg_we,
    input  logic [rgb2nv12_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgb2nv12_pkg::DIM_W-1:0]      cfg_data
);

    import rgb2nv12_pkg::*;

    logic               accept;
    pix_pos_t           pos;
    logic [PIX_W-1:0]   left_pixel;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_data;
    store_wr_t          store_wr;

    // Geometry, raster position and pair pixel
    rgb2nv12_raster u_raster (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pixel      (s_axis_tdata),
        .pos        (pos),
        .left_pixel (left_pixel)
    );

    // Pair sums of the even row
    rgb2nv12_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (store_wr.we),
        .waddr (store_wr.addr),
        .wdata (store_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Colour conversion pipeline
    rgb2nv12_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .accept        (accept),
        .pos           (pos),
        .left_pixel    (left_pixel),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .store_wr      (store_wr)
    );

endmodule

@@ rtl/core/rgb2nv12_checker.sv @@
`timescale 1ns / 1ps

module rgb2nv12_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rgb2nv12_pkg::PIX_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Chroma fields are zero unless a 2x2 block completes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("chroma not zero without chroma_valid");

    // Studio-swing luma range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd235)
        else $error("luma out of range");

    // Studio-swing chroma range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[15:8] >= 8'd16 && m_axis_tdata[15:8] <= 8'd240 &&
            m_axis_tdata[23:16] >= 8'd16 && m_axis_tdata[23:16] <= 8'd240)
        else $error("chroma out of range");

endmodule

bind rgb_to_nv12_converter_core rgb2nv12_checker u_checker (.*);

@@ verif/rgb_to_nv12_converter_core_tb.sv @@
`timescale 1ns / 1ps

module rgb_to_nv12_converter_core_tb;

    import rgb2nv12_pkg::*;

    localparam int     FRAC         = 16;
    localparam longint ONE          = longint'(1) << FRAC;
    localparam int     LATENCY      = 3;
    localparam int     IDLE_LIMIT   = 3000;
    localparam int     LONG_HOLD    = 500;
    localparam int     EDGE_ITEMS   = 64;
    localparam int     RANDOM_ITEMS = 240;
    localparam int     MAX_REPORTS  = 10;

    // Colour matrix weights, scaled by 2^16 and rounded to nearest
    localparam longint K_Y_R = (257 * ONE + 500) / 1000;
    localparam longint K_Y_G = (504 * ONE + 500) / 1000;
    localparam longint K_Y_B = (98 * ONE + 500) / 1000;
    localparam longint K_U_R = (148 * ONE + 500) / 1000;
    localparam longint K_U_G = (291 * ONE + 500) / 1000;
    localparam longint K_UV  = (439 * ONE + 500) / 1000;
    localparam longint K_V_G = (368 * ONE + 500) / 1000;
    localparam longint K_V_B = (71 * ONE + 500) / 1000;

    // Input pixel as laid out on s_axis_tdata (red in the low byte)
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       frame_end;
    } nv12_out_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;   // red, green, blue
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;         // luma, chroma_u, chroma_v
    logic                 m_axis_tuser;         // chroma_valid
    logic                 m_axis_tlast;         // frame_end
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data      = '0;

    rgb_pixel_t pixel_q[$];
    nv12_out_t  expected_q[$];
    int         error_count       = 0;
    logic       long_hold_request = 1'b0;

    // Converter state as the testbench sees it
    logic [DIM_W-1:0] width_shadow  = DIM_W'(640);
    logic [DIM_W-1:0] height_shadow = DIM_W'(480);
    logic [11:0]      col_pos       = '0;
    logic [11:0]      row_pos       = '0;
    rgb_pixel_t       held_px       = '0;
    logic [26:0]      pair_sums [2048];

    rgb_to_nv12_converter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Even geometry, clamped to 2..limit
    function automatic int even_dim(input logic [DIM_W-1:0] raw, input int limit);
        int d;
        d = int'(raw) & 32'h1FFE;
        if (d > limit)
            d = limit & ~1;
        if (d < 2)
            d = 2;
        return d;
    endfunction

    // Add offset, drop the fraction, clamp to a byte
    function automatic logic [7:0] to_byte(input longint acc, input longint offset);
        longint t;
        t = acc + offset * ONE;
        if (t < 0)
            return 8'd0;
        t = t >>> FRAC;
        if (t > 255)
            return 8'd255;
        return 8'(t);
    endfunction

    // Work out the result of one accepted pixel and advance the raster position
    task automatic predict_pixel(input rgb_pixel_t px);
        nv12_out_t   res;
        int          w;
        int          h;
        longint      ar;
        longint      ag;
        longint      ab;
        logic [8:0]  sr;
        logic [8:0]  sg;
        logic [8:0]  sb;
        logic [26:0] above;
        logic [10:0] idx;
        w   = even_dim(width_shadow, MAX_WIDTH);
        h   = even_dim(height_shadow, MAX_HEIGHT);
        res = '0;
        res.luma = to_byte(K_Y_R * longint'(px.red) + K_Y_G * longint'(px.green)
                           + K_Y_B * longint'(px.blue), 16);
        if (col_pos[0])
        begin
            sr  = {1'b0, px.red} + {1'b0, held_px.red};
            sg  = {1'b0, px.green} + {1'b0, held_px.green};
            sb  = {1'b0, px.blue} + {1'b0, held_px.blue};
            idx = col_pos[11:1];
            if (!row_pos[0])
                pair_sums[idx] = {sr, sg, sb};
            else
            begin
                above = pair_sums[idx];
                ar = (longint'(sr) + longint'(above[26:18])) >>> 2;
                ag = (longint'(sg) + longint'(above[17:9])) >>> 2;
                ab = (longint'(sb) + longint'(above[8:0])) >>> 2;
                res.chroma_u     = to_byte(K_UV * ab - K_U_R * ar - K_U_G * ag, 128);
                res.chroma_v     = to_byte(K_UV * ar - K_V_G * ag - K_V_B * ab, 128);
                res.chroma_valid = 1'b1;
            end
        end
        else
            held_px = px;
        res.frame_end = (int'(row_pos) >= h - 1) && (int'(col_pos) >= w - 1);
        // Row and frame wrap, also when a counter is already past a new limit
        if (int'(col_pos) >= w - 1)
        begin
            col_pos = '0;
            row_pos = (int'(row_pos) >= h - 1) ? 12'd0 : row_pos + 12'd1;
        end
        else
            col_pos = col_pos + 12'd1;
        expected_q.push_back(res);
    endtask

    function automatic rgb_pixel_t swatch(input int i);
        case (i % 8)
            0: return {8'h00, 8'h00, 8'h00};
            1: return {8'hFF, 8'hFF, 8'hFF};
            2: return {8'h00, 8'h00, 8'hFF};
            3: return {8'h00, 8'hFF, 8'h00};
            4: return {8'hFF, 8'h00, 8'h00};
            5: return {8'h00, 8'hFF, 8'hFF};
            6: return {8'hFF, 8'hFF, 8'h00};
            default: return {8'hFF, 8'h00, 8'hFF};
        endcase
    endfunction

    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t px;
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
        // Saturated channels now and then
        if ($urandom_range(0, 7) == 0)
            px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    // Small widths only: a wide odd row would pin the width for thousands of items
    function automatic logic [DIM_W-1:0] random_width();
        if ($urandom_range(0, 7) == 0)
            return DIM_W'($urandom_range(0, 1));
        return DIM_W'($urandom_range(2, 17));
    endfunction

    function automatic logic [DIM_W-1:0] random_height();
        case ($urandom_range(0, 9))
            0: return DIM_W'($urandom_range(0, 1));
            1: return DIM_W'($urandom_range(4096, 8191));
            2: return DIM_W'($urandom_range(4094, 4095));
            default: return DIM_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) pixel_q.push_back(random_pixel());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                             input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == REG_FRAME_WIDTH)
            width_shadow = value;
        else
            height_shadow = value;
        @(negedge clk);
    endtask

    // Wait until every pixel is in and every result is out, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Sender: bursts of items with random gaps, prediction at acceptance
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(rgb_pixel_t'(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left      = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(100, 400);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 32);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 8);
                        end
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: runs and stalls of random length, one long hold on request
    int  run_left  = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (long_hold_request && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left      = run_left - 1;
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            run_left      = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 24);
            stall_left    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end
    end

    // Result check against the oldest expected item
    always @(posedge clk)
    begin : result_check
        nv12_out_t seen;
        nv12_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.luma         = m_axis_tdata[7:0];
            seen.chroma_u     = m_axis_tdata[15:8];
            seen.chroma_v     = m_axis_tdata[23:16];
            seen.chroma_valid = m_axis_tuser;
            seen.frame_end    = m_axis_tlast;
            if (expected_q.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: luma %0d u %0d v %0d cv %0d end %0d",
                             seen.luma, seen.chroma_u, seen.chroma_v,
                             seen.chroma_valid, seen.frame_end);
            end
            else
            begin
                want = expected_q.pop_front();
                if (seen.luma !== want.luma || seen.chroma_valid !== want.chroma_valid
                    || seen.chroma_u !== want.chroma_u || seen.chroma_v !== want.chroma_v
                    || seen.frame_end !== want.frame_end)
                begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%s luma %0d/%0d cv %0d/%0d u %0d/%0d v %0d/%0d end %0d/%0d",
                                 "mismatch (exp/got):",
                                 want.luma, seen.luma, want.chroma_valid,
                                 seen.chroma_valid, want.chroma_u, seen.chroma_u,
                                 want.chroma_v, seen.chroma_v, want.frame_end,
                                 seen.frame_end);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int n;
        int random_count;
        random_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry, start of the first row
        for (i = 0; i < 6; i++)
            pixel_q.push_back(swatch(i));
        settle();

        // Shrink mid-row: the column is past the new width, so the row ends at once
        write_reg(REG_FRAME_WIDTH, DIM_W'(4));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(4));
        for (i = 0; i < 13; i++)
            pixel_q.push_back(swatch(i + 6));
        settle();

        // Geometry below two: zero width, height with only the low bit set
        write_reg(REG_FRAME_WIDTH, DIM_W'(0));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(1));
        for (i = 0; i < 4; i++)
            pixel_q.push_back(swatch(i + 3));
        settle();

        // Oversized width, start of a long even row, with a long output hold
        // while the input keeps coming
        write_reg(REG_FRAME_WIDTH, DIM_W'(8191));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(3));
        push_random(EDGE_ITEMS);
        long_hold_request = 1'b1;
        settle();

        // Oversized height, narrow rows; the long row ends on the first pixel
        write_reg(REG_FRAME_WIDTH, DIM_W'(1));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(8190));
        push_random(EDGE_ITEMS);
        settle();

        // Random geometry changes between runs of pixels; width only on even rows
        while (random_count < RANDOM_ITEMS)
        begin
            if (!row_pos[0] && $urandom_range(0, 1))
                write_reg(REG_FRAME_WIDTH, random_width());
            if ($urandom_range(0, 1))
                write_reg(REG_FRAME_HEIGHT, random_height());
            n = $urandom_range(4, 40);
            push_random(n);
            random_count = random_count + n;
            settle();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
